### sv/srcm_pkg.sv
// ----------------------------------------------------------------------------
// srcm_pkg
// Shared types and constants of the sparse residual check modulo q.
// ----------------------------------------------------------------------------
package srcm_pkg;

  localparam int MAX_COLUMNS    = 1024;
  localparam int COL_BITS       = $clog2(MAX_COLUMNS);
  localparam int COUNT_BITS     = 11;
  localparam int VALUE_BITS     = 64;
  localparam int ROW_COUNT_BITS = 16;
  localparam int ROW_NUM_BITS   = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_COUNT = 2'd1;

  typedef struct packed {
    logic [1:0]            operation;
    logic [COL_BITS-1:0]   column_index;
    logic [VALUE_BITS-1:0] operand_value;
  } req_t;

  typedef struct packed {
    logic [ROW_NUM_BITS-1:0] row_number;
    logic                    unsatisfied;
    logic                    column_error;
  } rsp_t;

  typedef struct packed {
    logic                  start;
    logic                  mul;
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] b;
  } mu_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] result;
  } mu_rsp_t;

endpackage

### sv/srcm_ram.sv
// ----------------------------------------------------------------------------
// srcm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module srcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/srcm_mod_unit.sv
// ----------------------------------------------------------------------------
// srcm_mod_unit
// Iterative modular unit: reduces a word mod q one bit a cycle, or forms
// (a * b) mod q most significant bit first with a double and an add step.
// ----------------------------------------------------------------------------
module srcm_mod_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [srcm_pkg::VALUE_BITS-1:0] q,
  input  srcm_pkg::mu_req_t               req,
  output srcm_pkg::mu_rsp_t               rsp
);

  localparam int W     = srcm_pkg::VALUE_BITS;
  localparam int CBITS = $clog2(W);

  logic             busy;
  logic             mul_mode;
  logic             phase;
  logic [CBITS-1:0] count;
  logic [W-1:0]     r;
  logic [W-1:0]     a;
  logic [W-1:0]     b;
  logic             done;

  logic             shift_in;
  logic [W:0]       cand;
  logic [W:0]       diff;
  logic [W-1:0]     red;
  logic             bit_step;

  always_comb begin
    shift_in = mul_mode ? 1'b0 : a[W-1];
    if (mul_mode && phase) begin
      cand = {1'b0, r} + {1'b0, b};
    end else begin
      cand = {r, shift_in};
    end
    diff     = cand - {1'b0, q};
    red      = (cand >= {1'b0, q}) ? diff[W-1:0] : cand[W-1:0];
    bit_step = !mul_mode || phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy     <= 1'b1;
        mul_mode <= req.mul;
        phase    <= 1'b0;
        count    <= '0;
        r        <= '0;
        a        <= req.a;
        b        <= req.b;
      end else if (busy) begin
        phase <= mul_mode ? ~phase : 1'b0;
        if (!mul_mode || !phase || a[W-1]) begin
          r <= red;
        end
        if (bit_step) begin
          a     <= {a[W-2:0], 1'b0};
          count <= count + 1'b1;
          if (count == CBITS'(W - 1)) begin
            busy <= 1'b0;
          end
        end
      end
      done <= !req.start && busy && bit_step && (count == CBITS'(W - 1));
    end
  end

  assign rsp.done   = done;
  assign rsp.result = r;

endmodule

### sv/sparse_residual_check_mod_q_core.sv
// ----------------------------------------------------------------------------
// sparse_residual_check_mod_q_core
// Checks a candidate solution of a sparse linear system modulo a prime q.
// ----------------------------------------------------------------------------
// Solution words are written into a 1024 x 64 store by column; a load is
// written straight from the request. A matrix entry reads its solution word,
// then runs four passes of one shared bit-serial modular unit: three
// reductions (coefficient, solution word, accumulator) and a multiply whose
// product is added to the accumulator; an entry with a bad column or under a
// trivial modulus does not use the unit. A row close reduces accumulator and
// target (under a trivial modulus it skips both), and then waits for the
// result register to be free. One transaction is in work at a time; the
// result register lets the next one in while a result waits.
// ----------------------------------------------------------------------------
module sparse_residual_check_mod_q_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [srcm_pkg::VALUE_BITS-1:0]     cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  srcm_pkg::req_t                      req_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output srcm_pkg::rsp_t                      rsp_data
);

  localparam int W = srcm_pkg::VALUE_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_COEF = 4'd2;
  localparam logic [3:0] S_WORD = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_CACC = 4'd6;
  localparam logic [3:0] S_CTGT = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]                            state;
  logic [3:0]                            state_next;
  logic [W-1:0]                          modulus;
  logic [srcm_pkg::COUNT_BITS-1:0]       column_count;
  logic [W-1:0]                          acc;
  logic [srcm_pkg::ROW_COUNT_BITS-1:0]   row_counter;
  logic                                  bad_seen;
  logic [W-1:0]                          held;
  logic [W-1:0]                          cr;
  logic [W-1:0]                          sr;
  logic [W-1:0]                          ar;
  logic                                  unsat;

  logic                                  accept;
  logic                                  trivial;
  logic                                  bad_col;
  logic                                  ram_we;
  logic                                  ram_re;
  logic [W-1:0]                          ram_rdata;
  logic [W:0]                            sum;
  logic [W:0]                            sum_diff;
  logic [W-1:0]                          acc_next;
  logic                                  out_free;

  srcm_pkg::mu_req_t                     mu_req;
  srcm_pkg::mu_rsp_t                     mu_rsp;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign trivial   = (modulus[W-1:1] == '0);
  assign bad_col   = ({1'b0, req_data.column_index} >= column_count);
  assign ram_we    = accept && (req_data.operation == srcm_pkg::OP_LOAD);
  assign ram_re    = accept && (req_data.operation == srcm_pkg::OP_ENTRY) &&
                     !bad_col && !trivial;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign sum      = {1'b0, ar} + {1'b0, mu_rsp.result};
  assign sum_diff = sum - {1'b0, modulus};
  assign acc_next = (sum >= {1'b0, modulus}) ? sum_diff[W-1:0] : sum[W-1:0];

  srcm_ram #(
    .WIDTH(W),
    .DEPTH(srcm_pkg::MAX_COLUMNS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(req_data.column_index),
    .wdata(req_data.operand_value),
    .re   (ram_re),
    .raddr(req_data.column_index),
    .rdata(ram_rdata)
  );

  srcm_mod_unit u_mod (
    .clk(clk),
    .rst(rst),
    .q  (modulus),
    .req(mu_req),
    .rsp(mu_rsp)
  );

  // sequencer and unit requests
  always_comb begin
    state_next   = state;
    mu_req.start = 1'b0;
    mu_req.mul   = 1'b0;
    mu_req.a     = '0;
    mu_req.b     = sr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_data.operation)
            srcm_pkg::OP_ENTRY: begin
              if (!bad_col && !trivial) begin
                state_next = S_READ;
              end
            end
            srcm_pkg::OP_CLOSE: begin
              if (trivial) begin
                state_next = S_OUT;
              end else begin
                mu_req.start = 1'b1;
                mu_req.a     = acc;
                state_next   = S_CACC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        mu_req.start = 1'b1;
        mu_req.a     = held;
        state_next   = S_COEF;
      end
      S_COEF: begin
        if (mu_rsp.done) begin
          mu_req.start = 1'b1;
          mu_req.a     = ram_rdata;
          state_next   = S_WORD;
        end
      end
      S_WORD: begin
        if (mu_rsp.done) begin
          mu_req.start = 1'b1;
          mu_req.a     = acc;
          state_next   = S_ACC;
        end
      end
      S_ACC: begin
        if (mu_rsp.done) begin
          mu_req.start = 1'b1;
          mu_req.mul   = 1'b1;
          mu_req.a     = cr;
          mu_req.b     = sr;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        if (mu_rsp.done) begin
          state_next = S_IDLE;
        end
      end
      S_CACC: begin
        if (mu_rsp.done) begin
          mu_req.start = 1'b1;
          mu_req.a     = held;
          state_next   = S_CTGT;
        end
      end
      S_CTGT: begin
        if (mu_rsp.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      modulus      <= W'(2);
      column_count <= srcm_pkg::COUNT_BITS'(1);
      acc          <= '0;
      row_counter  <= '0;
      bad_seen     <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          srcm_pkg::CFG_MODULUS:      modulus <= cfg_data;
          srcm_pkg::CFG_COLUMN_COUNT: column_count <= cfg_data[srcm_pkg::COUNT_BITS-1:0];
          default: begin
          end
        endcase
      end

      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            held <= req_data.operand_value;
            if (req_data.operation == srcm_pkg::OP_ENTRY) begin
              if (bad_col) begin
                bad_seen <= 1'b1;
              end else if (trivial) begin
                acc <= '0;
              end
            end
            if (req_data.operation == srcm_pkg::OP_CLOSE && trivial) begin
              unsat <= 1'b0;
            end
          end
        end
        S_COEF: begin
          if (mu_rsp.done) begin
            cr <= mu_rsp.result;
          end
        end
        S_WORD: begin
          if (mu_rsp.done) begin
            sr <= mu_rsp.result;
          end
        end
        S_ACC, S_CACC: begin
          if (mu_rsp.done) begin
            ar <= mu_rsp.result;
          end
        end
        S_MUL: begin
          if (mu_rsp.done) begin
            acc <= acc_next;
          end
        end
        S_CTGT: begin
          if (mu_rsp.done) begin
            unsat <= (ar != mu_rsp.result);
          end
        end
        S_OUT: begin
          if (out_free) begin
            rsp_valid                <= 1'b1;
            rsp_data.row_number      <= row_counter;
            rsp_data.unsatisfied     <= unsat;
            rsp_data.column_error    <= bad_seen;
            row_counter              <= row_counter + 1'b1;
            acc                      <= '0;
            bad_seen                 <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
